### rtl/rclfp_pkg.sv
package rclfp_pkg;

  localparam logic [7:0] HDR_FIRST = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hFC;

  localparam int unsigned PAYLOAD_COUNT = 12;
  localparam int unsigned PAYLOAD_IDX_W = $clog2(PAYLOAD_COUNT);

  typedef logic [4:0] pos_t;

  localparam pos_t POS_HDR_FIRST = 5'd0;
  localparam pos_t POS_HDR_SECOND = 5'd1;
  localparam pos_t POS_PAYLOAD_FIRST = 5'd2;
  localparam pos_t POS_PAYLOAD_LAST = 5'd13;
  localparam pos_t POS_EXTRA_LAST = 5'd15;
  localparam pos_t POS_SUM_HIGH = 5'd16;
  localparam pos_t POS_FRAME_LAST = 5'd17;

  typedef struct packed {
    logic [15:0] chan1;
    logic [15:0] chan2;
    logic [15:0] chan3;
    logic [15:0] chan4;
    logic [15:0] chan5;
    logic [15:0] chan6;
  } chan_set_t;

  typedef struct packed {
    logic load;
    chan_set_t chans;
  } result_load_t;

endpackage

### rtl/rclfp_byte_if.sv
interface rclfp_byte_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/rclfp_chan_if.sv
interface rclfp_chan_if;
  logic valid;
  logic ready;
  logic [15:0] chan1;
  logic [15:0] chan2;
  logic [15:0] chan3;
  logic [15:0] chan4;
  logic [15:0] chan5;
  logic [15:0] chan6;

  modport source (output valid, output chan1, output chan2, output chan3,
                  output chan4, output chan5, output chan6, input ready);
  modport sink (input valid, input chan1, input chan2, input chan3,
                input chan4, input chan5, input chan6, output ready);
endinterface

### rtl/rclfp_parser.sv
module rclfp_parser
  import rclfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rclfp_byte_if.sink   rx,
  input  logic         out_busy,
  output result_load_t result
);

  pos_t        pos;
  pos_t        pos_next;
  logic [15:0] sum;
  logic [15:0] sum_next;
  logic [7:0]  sum_high;
  logic [7:0]  payload [PAYLOAD_COUNT];
  logic        accept;
  logic        payload_wr;
  logic        sum_high_wr;
  logic        match;
  logic [PAYLOAD_IDX_W-1:0] idx;

  // hold the last byte while the result register cannot take a frame
  assign rx.ready = !((pos == POS_FRAME_LAST) && out_busy);
  assign accept   = rx.valid && rx.ready;

  assign idx    = PAYLOAD_IDX_W'(pos - POS_PAYLOAD_FIRST);
  assign match  = ({sum_high, rx.rx_byte} == sum);

  always_comb begin
    pos_next    = POS_HDR_FIRST;
    sum_next    = sum;
    payload_wr  = 1'b0;
    sum_high_wr = 1'b0;
    result.load = 1'b0;
    result.chans.chan1 = {payload[0], payload[1]};
    result.chans.chan2 = {payload[2], payload[3]};
    result.chans.chan3 = {payload[4], payload[5]};
    result.chans.chan4 = {payload[6], payload[7]};
    result.chans.chan5 = {payload[8], payload[9]};
    result.chans.chan6 = {payload[10], payload[11]};
    if (pos == POS_HDR_FIRST) begin
      pos_next = (rx.rx_byte == HDR_FIRST) ? POS_HDR_SECOND : POS_HDR_FIRST;
    end else if (pos == POS_HDR_SECOND) begin
      if (rx.rx_byte == HDR_SECOND) begin
        pos_next = POS_PAYLOAD_FIRST;
        sum_next = '0;
      end
    end else if (pos <= POS_EXTRA_LAST) begin
      payload_wr = (pos <= POS_PAYLOAD_LAST);
      sum_next   = sum + {8'd0, rx.rx_byte};
      pos_next   = pos + 5'd1;
    end else if (pos == POS_SUM_HIGH) begin
      sum_high_wr = 1'b1;
      pos_next    = POS_FRAME_LAST;
    end else if (pos == POS_FRAME_LAST) begin
      result.load = accept && match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HDR_FIRST;
      sum      <= '0;
      sum_high <= '0;
    end else if (accept) begin
      pos <= pos_next;
      sum <= sum_next;
      if (sum_high_wr) begin
        sum_high <= rx.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && payload_wr) begin
      payload[idx] <= rx.rx_byte;
    end
  end

endmodule

### rtl/rclfp_out_stage.sv
module rclfp_out_stage
  import rclfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_load_t result,
  output logic         out_busy,
  rclfp_chan_if.source frame
);

  logic      valid;
  logic      valid_next;
  chan_set_t chans;

  assign out_busy = valid && !frame.ready;

  always_comb begin
    valid_next = valid && !frame.ready;
    if (result.load) begin
      valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      chans <= result.chans;
    end
  end

  assign frame.valid = valid;
  assign frame.chan1 = chans.chan1;
  assign frame.chan2 = chans.chan2;
  assign frame.chan3 = chans.chan3;
  assign frame.chan4 = chans.chan4;
  assign frame.chan5 = chans.chan5;
  assign frame.chan6 = chans.chan6;

endmodule

### rtl/rc_link_frame_parser.sv
// Byte-serial parser for 18-byte remote-control frames.
// Channel rx (sink): one received byte per request in rx_byte.
// Channel frame (source): six 16-bit channels, chan1..chan6, one request
// per frame whose 16-bit checksum over bytes 2 to 15 matches.
// A frame opens with 0x55 0xFC; a wrong header byte is consumed and the
// parser waits for a new first header byte. Bad frames are dropped.
// Throughput: one byte per cycle unless a frame's last byte is held;
// header check, payload store and 16-bit checksum add are combinational.
// Latency: the channel request is valid in the cycle after the last
// checksum byte is taken.
// Reset (rst, synchronous): parser returns to awaiting the first header
// byte, the running sum clears and no channel request is pending.
// Stall: while a channel request waits, bytes keep flowing; only the last
// byte of the next frame is held until the waiting request is taken.
module rc_link_frame_parser
  import rclfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rclfp_byte_if.sink   rx,
  rclfp_chan_if.source frame
);

  result_load_t result;
  logic         out_busy;

  rclfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .out_busy (out_busy),
    .result   (result)
  );

  rclfp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .out_busy (out_busy),
    .frame    (frame)
  );

endmodule
